// File: rtl/aligned_run_block_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Aligned run block allocator assertion macros
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_RUN_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define ALIGNED_RUN_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define ARBA_ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define ARBA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ARBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ARBA_ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ARBA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ARBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/arba_pkg.sv
// ----------------------------------------------------------------------------
// Aligned run block allocator package
// Request and response types, codes and reset constants.
// ----------------------------------------------------------------------------
package arba_pkg;

    localparam int MAX_BLOCKS_DEF = 1024;
    localparam int LEN_W          = 11;
    localparam int BLK_W          = 10;
    localparam int BSL2_W         = 5;
    localparam int ALIGN_W        = 5;
    localparam int STATUS_W       = 2;
    localparam int OFFSET_W       = 32;
    localparam int CFG_DATA_W     = 11;

    localparam int POOL_RESET     = 1024;
    localparam logic [BSL2_W-1:0] BSL2_RESET = 5'd8;
    localparam logic [BSL2_W-1:0] BSL2_MAX   = 5'd20;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    localparam logic CFG_POOL_BLOCKS = 1'b0;
    localparam logic CFG_BLOCK_SIZE  = 1'b1;

    typedef struct packed {
        logic               func;
        logic [LEN_W-1:0]   run_length;
        logic [ALIGN_W-1:0] offset_align_log2;
        logic [BLK_W-1:0]   start_block;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    run_start;
        logic [OFFSET_W-1:0] byte_offset;
        logic [LEN_W-1:0]    free_blocks;
    } rsp_t;

endpackage

// File: rtl/arba_store.sv
// ----------------------------------------------------------------------------
// Aligned run block allocator storage
// Free map and run length memories, one write and one read port each.
// ----------------------------------------------------------------------------
module arba_store #(
    parameter int MAX_BLOCKS = arba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                             clk,
    input  logic                             free_we,
    input  logic [$clog2(MAX_BLOCKS)-1:0]    free_waddr,
    input  logic                             free_wdata,
    input  logic [$clog2(MAX_BLOCKS)-1:0]    free_raddr,
    output logic                             free_rdata,
    input  logic                             len_we,
    input  logic [$clog2(MAX_BLOCKS)-1:0]    len_waddr,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]  len_wdata,
    input  logic [$clog2(MAX_BLOCKS)-1:0]    len_raddr,
    output logic [$clog2(MAX_BLOCKS+1)-1:0]  len_rdata
);

    import arba_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic             free_mem [MAX_BLOCKS];
    logic [CNT_W-1:0] len_mem  [MAX_BLOCKS];

    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[free_waddr] <= free_wdata;
        end
        free_rdata <= free_mem[free_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rdata <= len_mem[len_raddr];
    end

endmodule

// File: rtl/aligned_run_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// Aligned run block allocator
// First-fit allocator of aligned runs of equal blocks with a serial scan.
// ----------------------------------------------------------------------------
// Requests arrive on the req channel (allocate or free) and each one yields
// exactly one response on the rsp channel with status, run start, byte offset
// and the remaining free block count, unless a pool size write aborts it.
// Configuration writes use the cfg channel; register 0 sets the pool size and
// empties the pool, register 1 sets the block size.
// The free map is scanned one block per cycle. An allocate is accepted, scans
// the free map for the first aligned free run of run_length blocks, marks
// those blocks and then responds. A free reads the run length stored at its
// start block, releases each block of the run and then responds. Rejected
// requests skip the scan and the writes. One request is in work at a time.
// After reset, and after every pool size write, a clearing pass over all
// MAX_BLOCKS entries initializes both memories; req_ready stays low during it
// while configuration writes are still taken.
// The response sits in an output register. A new request is taken while it
// waits, but the next response holds until the receiver takes the previous.
// ----------------------------------------------------------------------------
`include "aligned_run_block_allocator_unit_macros.svh"

module aligned_run_block_allocator_unit #(
    parameter int MAX_BLOCKS = arba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  arba_pkg::req_t                     req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output arba_pkg::rsp_t                     rsp,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [arba_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import arba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int POOL_RST = (POOL_RESET > MAX_BLOCKS) ? MAX_BLOCKS : POOL_RESET;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [CNT_W-1:0]      run_reg, run_next;
    logic [CNT_W-1:0]      len_reg, len_next;
    logic [IDX_W-1:0]      amask_reg, amask_next;
    logic [CW-1:0]         blk_reg, blk_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [IDX_W-1:0]      wr_addr_reg, wr_addr_next;
    logic [CNT_W-1:0]      wr_cnt_reg, wr_cnt_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [CNT_W-1:0]      pool_reg, pool_next;
    logic [BSL2_W-1:0]     bsl2_reg, bsl2_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  free_we;
    logic [IDX_W-1:0]      free_waddr;
    logic                  free_wdata;
    logic                  free_rdata;
    logic                  len_we;
    logic [IDX_W-1:0]      len_waddr;
    logic [CNT_W-1:0]      len_wdata;
    logic [CNT_W-1:0]      len_rdata;

    logic [CW-1:0]         len_cw;
    logic [CW-1:0]         sb_cw;
    logic [CW-1:0]         pool_cw;
    logic [CW-1:0]         cfg_cw;
    logic [CW-1:0]         free_cw;
    logic [63:0]           boff_wide;
    logic [ALIGN_W-1:0]    need;
    logic [IDX_W-1:0]      amask_calc;
    logic [CNT_W-1:0]      run_cur;
    logic [CNT_W-1:0]      cand;
    logic                  aligned;
    logic                  req_fire;

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign req_fire  = req_valid && req_ready;

    assign len_cw    = CW'(req.run_length);
    assign sb_cw     = CW'(req.start_block);
    assign pool_cw   = CW'(pool_reg);
    assign cfg_cw    = CW'(cfg_data);
    assign free_cw   = CW'(pool_reg - used_reg);
    assign boff_wide = 64'(blk_reg) << bsl2_reg;

    assign need = (req.offset_align_log2 > bsl2_reg) ?
                  (req.offset_align_log2 - bsl2_reg) : '0;

    always_comb
    begin
        for (int b = 0; b < IDX_W; b++)
        begin
            amask_calc[b] = (b < int'(need));
        end
    end

    assign run_cur = free_rdata ? (run_reg + CNT_W'(1)) : '0;
    assign cand    = idx_reg + CNT_W'(1) - len_reg;
    assign aligned = ((cand[IDX_W-1:0] & amask_reg) == '0);

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        idx_next       = idx_reg;
        run_next       = run_reg;
        len_next       = len_reg;
        amask_next     = amask_reg;
        blk_next       = blk_reg;
        status_next    = status_reg;
        wr_addr_next   = wr_addr_reg;
        wr_cnt_next    = wr_cnt_reg;
        used_next      = used_reg;
        pool_next      = pool_reg;
        bsl2_next      = bsl2_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        free_we    = 1'b0;
        free_waddr = wr_addr_reg;
        free_wdata = 1'b0;
        len_we     = 1'b0;
        len_waddr  = blk_reg[IDX_W-1:0];
        len_wdata  = len_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                free_we    = 1'b1;
                free_waddr = clr_addr_reg;
                free_wdata = 1'b1;
                len_we     = 1'b1;
                len_waddr  = clr_addr_reg;
                len_wdata  = '0;
                if (clr_addr_reg == IDX_W'(MAX_BLOCKS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.func == FUNC_ALLOC)
                    begin
                        blk_next   = '0;
                        idx_next   = '0;
                        run_next   = '0;
                        amask_next = amask_calc;
                        len_next   = CNT_W'(len_cw);
                        if (len_cw == '0)
                        begin
                            status_next = STATUS_INVALID;
                            state_next  = S_DONE;
                        end
                        else if (len_cw > pool_cw)
                        begin
                            status_next = STATUS_NOFIT;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        blk_next     = sb_cw;
                        wr_addr_next = sb_cw[IDX_W-1:0];
                        if (sb_cw >= pool_cw)
                        begin
                            status_next = STATUS_INVALID;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_FREE_RD;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                run_next = run_cur;
                if ((run_cur >= len_reg) && aligned)
                begin
                    blk_next     = CW'(cand);
                    wr_addr_next = cand[IDX_W-1:0];
                    wr_cnt_next  = len_reg;
                    state_next   = S_MARK;
                end
                else if (idx_reg == pool_reg - CNT_W'(1))
                begin
                    status_next = STATUS_NOFIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            S_MARK:
            begin
                free_we      = 1'b1;
                free_wdata   = 1'b0;
                len_we       = 1'b1;
                len_wdata    = len_reg;
                wr_addr_next = wr_addr_reg + IDX_W'(1);
                wr_cnt_next  = wr_cnt_reg - CNT_W'(1);
                if (wr_cnt_reg == CNT_W'(1))
                begin
                    used_next   = used_reg + len_reg;
                    status_next = STATUS_OK;
                    state_next  = S_DONE;
                end
            end

            S_FREE_RD:
            begin
                if (len_rdata == '0)
                begin
                    status_next = STATUS_INVALID;
                    state_next  = S_DONE;
                end
                else
                begin
                    len_next    = len_rdata;
                    wr_cnt_next = len_rdata;
                    state_next  = S_FREE_WR;
                end
            end

            S_FREE_WR:
            begin
                free_we      = 1'b1;
                free_wdata   = 1'b1;
                len_we       = 1'b1;
                len_wdata    = '0;
                wr_addr_next = wr_addr_reg + IDX_W'(1);
                wr_cnt_next  = wr_cnt_reg - CNT_W'(1);
                if (wr_cnt_reg == CNT_W'(1))
                begin
                    used_next   = (used_reg >= len_reg) ? (used_reg - len_reg) : '0;
                    status_next = STATUS_OK;
                    state_next  = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.status      = status_reg;
                    rsp_next.run_start   = blk_reg[BLK_W-1:0];
                    rsp_next.byte_offset = boff_wide[OFFSET_W-1:0];
                    rsp_next.free_blocks = free_cw[LEN_W-1:0];
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_POOL_BLOCKS)
            begin
                if (cfg_cw == '0)
                begin
                    pool_next = CNT_W'(1);
                end
                else if (cfg_cw > CW'(MAX_BLOCKS))
                begin
                    pool_next = CNT_W'(MAX_BLOCKS);
                end
                else
                begin
                    pool_next = CNT_W'(cfg_cw);
                end
                used_next     = '0;
                clr_addr_next = '0;
                state_next    = S_CLEAR;
            end
            else
            begin
                bsl2_next = (cfg_data[BSL2_W-1:0] > BSL2_MAX) ?
                            BSL2_MAX : cfg_data[BSL2_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            idx_reg       <= '0;
            run_reg       <= '0;
            len_reg       <= '0;
            amask_reg     <= '0;
            blk_reg       <= '0;
            status_reg    <= STATUS_OK;
            wr_addr_reg   <= '0;
            wr_cnt_reg    <= '0;
            used_reg      <= '0;
            pool_reg      <= CNT_W'(POOL_RST);
            bsl2_reg      <= BSL2_RESET;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            idx_reg       <= idx_next;
            run_reg       <= run_next;
            len_reg       <= len_next;
            amask_reg     <= amask_next;
            blk_reg       <= blk_next;
            status_reg    <= status_next;
            wr_addr_reg   <= wr_addr_next;
            wr_cnt_reg    <= wr_cnt_next;
            used_reg      <= used_next;
            pool_reg      <= pool_next;
            bsl2_reg      <= bsl2_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    arba_store #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_store (
        .clk        (clk),
        .free_we    (free_we),
        .free_waddr (free_waddr),
        .free_wdata (free_wdata),
        .free_raddr (idx_next[IDX_W-1:0]),
        .free_rdata (free_rdata),
        .len_we     (len_we),
        .len_waddr  (len_waddr),
        .len_wdata  (len_wdata),
        .len_raddr  (sb_cw[IDX_W-1:0]),
        .len_rdata  (len_rdata)
    );

    // The used count can never exceed the configured pool.
    `ARBA_ASSERT_ALWAYS(a_used_within_pool, clk, rst_n, used_reg <= pool_reg)
    // An accepted request keeps the block busy in the following cycle.
    `ARBA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_fire, !req_ready)
    // A pool size write starts a clearing pass that blocks new requests.
    `ARBA_ASSERT_NEXT(a_pool_write_clears, clk, rst_n, cfg_valid && cfg_ready && (cfg_index == CFG_POOL_BLOCKS), state_reg == S_CLEAR)
    // Marking writes stay inside the pool.
    `ARBA_ASSERT_IMPL(a_mark_in_pool, clk, rst_n, state_reg == S_MARK, CNT_W'(wr_addr_reg) < pool_reg)

endmodule
